/* rtl/core/assert_macros.svh */
// Assertion macros used by the checker file of this block.
// No dependencies; include with the bare file name.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// Same-cycle implication, disabled while reset is high.
`define ASSERT_SAME(label, clk, rst, ante, cons) \
  label: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) \
    else $error("same-cycle check failed");

// Next-cycle implication, disabled while reset is high.
`define ASSERT_NEXT(label, clk, rst, ante, cons) \
  label: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) \
    else $error("next-cycle check failed");

`endif

/* rtl/core/bppc_pkg.sv */
// Shared constants and types for the bounded part partition counter.
// No dependencies; used by the core through scoped names.
package bppc_pkg;

  localparam int MAX_AMOUNT = 256;
  localparam int DEPTH      = MAX_AMOUNT + 1;
  localparam int ADDR_W     = $clog2(DEPTH);
  localparam int AMT_W      = 9;
  localparam int CNT_W      = 64;
  localparam int WAY_W      = 63;

  typedef logic [AMT_W-1:0]  amt_t;
  typedef logic [ADDR_W-1:0] addr_t;
  typedef logic [CNT_W-1:0]  cnt_t;
  typedef logic [WAY_W-1:0]  way_t;

  localparam logic [1:0] MODE_ANY   = 2'd1;
  localparam logic [1:0] MODE_UPPER = 2'd2;
  localparam logic [1:0] MODE_RANGE = 2'd3;

endpackage

/* rtl/core/bppc_ram.sv */
// Generic RAM: one write port, two read ports, registered read data.
// No dependencies.
module bppc_ram #(
  parameter int WIDTH = 64,
  parameter int DEPTH = 257
) (
  input  logic                     clk,
  input  logic                     we,
  input  logic [$clog2(DEPTH)-1:0] waddr,
  input  logic [WIDTH-1:0]         wdata,
  input  logic [$clog2(DEPTH)-1:0] raddr_a,
  input  logic [$clog2(DEPTH)-1:0] raddr_b,
  output logic [WIDTH-1:0]         rdata_a,
  output logic [WIDTH-1:0]         rdata_b
);

  logic [WIDTH-1:0] mem [DEPTH];

  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    rdata_a <= mem[raddr_a];
    rdata_b <= mem[raddr_b];
  end

endmodule

/* rtl/core/bounded_part_partition_counter_core.sv */
// Channel   Signals                                       Handshake
// query     amount, mode, first_bound, second_bound       taken when start && !busy
// result    way_count                                     valid for one cycle on done
//
// An item first initialises the count RAM entries 0..A (one way at entry 0), then for
// each part p = 1..T sweeps entries p..A with one read-modify-write add each (S_READ,
// S_WRITE), A the saturated amount and T the clamped top part; S_FINISH then
// registers the result. Items with no valid mode or crossed bounds go straight to
// S_FINISH. The result strobe cannot be held off, so nothing stalls the sequencer
// once an item is taken. Reset is synchronous and returns the sequencer to idle;
// the RAM needs no clearing since each item rebuilds its entries.
// Depends on bppc_pkg and bppc_ram.
module bounded_part_partition_counter_core (
  input  logic                  clk,
  input  logic                  rst,
  input  logic                  start,
  output logic                  busy,
  input  bppc_pkg::amt_t        amount,
  input  logic [1:0]            mode,
  input  bppc_pkg::amt_t        first_bound,
  input  bppc_pkg::amt_t        second_bound,
  output logic                  done,
  output bppc_pkg::way_t        way_count
);

  typedef enum logic [2:0] {
    S_IDLE,
    S_INIT,
    S_READ,
    S_WRITE,
    S_FINISH
  } state_t;

  state_t            state;
  bppc_pkg::addr_t   p;
  bppc_pkg::addr_t   v;
  bppc_pkg::addr_t   amt_q;
  bppc_pkg::addr_t   top_q;
  bppc_pkg::addr_t   snap_q;
  logic              sub_en;
  bppc_pkg::cnt_t    cur;
  bppc_pkg::cnt_t    snapshot;

  bppc_pkg::addr_t   amt_c;
  bppc_pkg::amt_t    lo_c;
  bppc_pkg::amt_t    lo_m1;
  bppc_pkg::addr_t   top_c;
  bppc_pkg::addr_t   snap_c;
  logic              valid_c;
  logic              range_c;

  logic              ram_we;
  bppc_pkg::cnt_t    ram_wdata;
  bppc_pkg::cnt_t    rd_a;
  bppc_pkg::cnt_t    rd_b;
  bppc_pkg::cnt_t    sum;
  bppc_pkg::cnt_t    start_cnt;

  // Decode the query into amount, top part size and snapshot point.
  always_comb begin
    amt_c = (amount > bppc_pkg::amt_t'(bppc_pkg::MAX_AMOUNT)) ?
            bppc_pkg::addr_t'(bppc_pkg::MAX_AMOUNT) : bppc_pkg::addr_t'(amount);
    lo_c  = (first_bound == '0) ? bppc_pkg::amt_t'(1) : first_bound;
    lo_m1 = lo_c - bppc_pkg::amt_t'(1);
    top_c   = amt_c;
    snap_c  = amt_c;
    valid_c = 1'b1;
    range_c = 1'b0;
    case (mode)
      bppc_pkg::MODE_ANY: begin
        top_c  = amt_c;
        snap_c = amt_c;
      end
      bppc_pkg::MODE_UPPER: begin
        top_c  = (first_bound > amt_c) ? amt_c : bppc_pkg::addr_t'(first_bound);
        snap_c = top_c;
      end
      bppc_pkg::MODE_RANGE: begin
        range_c = 1'b1;
        valid_c = (second_bound >= lo_c);
        top_c   = (second_bound > amt_c) ? amt_c : bppc_pkg::addr_t'(second_bound);
        snap_c  = (lo_m1 > top_c) ? top_c : bppc_pkg::addr_t'(lo_m1);
      end
      default: begin
        valid_c = 1'b0;
      end
    endcase
  end

  // Entry of the amount after the first clearing pass: one way for an empty amount.
  assign start_cnt = (amt_c == '0) ? bppc_pkg::cnt_t'(1) : '0;

  assign sum       = rd_a + rd_b;
  assign ram_we    = (state == S_INIT) || (state == S_WRITE);
  assign ram_wdata = (state == S_INIT) ? ((v == '0) ? bppc_pkg::cnt_t'(1) : '0) : sum;
  assign busy      = (state != S_IDLE);

  bppc_ram #(
    .WIDTH (bppc_pkg::CNT_W),
    .DEPTH (bppc_pkg::DEPTH)
  ) u_counts (
    .clk     (clk),
    .we      (ram_we),
    .waddr   (v),
    .wdata   (ram_wdata),
    .raddr_a (v),
    .raddr_b (v - p),
    .rdata_a (rd_a),
    .rdata_b (rd_b)
  );

  always_ff @(posedge clk) begin
    if (rst) begin
      state    <= S_IDLE;
      done     <= 1'b0;
      snapshot <= '0;
    end else begin
      done <= (state == S_FINISH);
      case (state)
        S_IDLE: begin
          if (start) begin
            amt_q  <= amt_c;
            top_q  <= top_c;
            snap_q <= snap_c;
            sub_en <= range_c & valid_c;
            v      <= '0;
            if (valid_c) begin
              cur <= start_cnt;
              if (snap_c == '0) begin
                snapshot <= start_cnt;
              end
              state <= S_INIT;
            end else begin
              cur    <= '0;
              state  <= S_FINISH;
            end
          end
        end
        S_INIT: begin
          if (v == amt_q) begin
            if (top_q == '0) begin
              state <= S_FINISH;
            end else begin
              p     <= bppc_pkg::addr_t'(1);
              v     <= bppc_pkg::addr_t'(1);
              state <= S_READ;
            end
          end else begin
            v <= v + bppc_pkg::addr_t'(1);
          end
        end
        S_READ: begin
          state <= S_WRITE;
        end
        S_WRITE: begin
          // The last write of each part's sweep lands on the amount's entry.
          if (v == amt_q) begin
            cur <= sum;
            if (p == snap_q) begin
              snapshot <= sum;
            end
            if (p == top_q) begin
              state <= S_FINISH;
            end else begin
              p     <= p + bppc_pkg::addr_t'(1);
              v     <= p + bppc_pkg::addr_t'(1);
              state <= S_READ;
            end
          end else begin
            v     <= v + bppc_pkg::addr_t'(1);
            state <= S_READ;
          end
        end
        S_FINISH: begin
          way_count <= sub_en ? bppc_pkg::way_t'(cur - snapshot) : bppc_pkg::way_t'(cur);
          state     <= S_IDLE;
        end
        default: begin
          state <= S_IDLE;
        end
      endcase
    end
  end

endmodule

/* rtl/core/bppc_checker.sv */
// Port-level checks on the core's command handshake and result strobe,
// bound to the core module. Depends on assert_macros.svh.
`include "assert_macros.svh"

module bppc_checker (
  input logic clk,
  input logic rst,
  input logic start,
  input logic busy,
  input logic done
);

  // An accepted item always makes the core busy on the next cycle.
  `ASSERT_NEXT(a_start_busy, clk, rst, start && !busy, busy)
  // The result strobe lasts a single cycle.
  `ASSERT_NEXT(a_done_pulse, clk, rst, done, !done)
  // A result appears only once the core is free again.
  `ASSERT_SAME(a_done_idle, clk, rst, done, !busy)
  // The core leaves its busy phase only by delivering a result.
  `ASSERT_SAME(a_fall_done, clk, rst, !$past(rst) && $fell(busy), done)

endmodule

bind bounded_part_partition_counter_core bppc_checker u_bppc_checker (
  .clk   (clk),
  .rst   (rst),
  .start (start),
  .busy  (busy),
  .done  (done)
);
